/* design/ksmm_pkg.sv */
package ksmm_pkg;

	localparam int unsigned NumKeys = 256;
	localparam int unsigned CodeW   = $clog2(NumKeys);
	localparam int unsigned ModKeys = 6;
	localparam int unsigned ModW    = $clog2(ModKeys);

	typedef logic [CodeW-1:0] code_t;

	localparam code_t CodeShift  = code_t'(8'h10);
	localparam code_t CodeLShift = code_t'(8'hA0);
	localparam code_t CodeRAlt   = code_t'(8'hA5);

	typedef struct packed {
		code_t key_code;
		logic  is_press;
		logic  is_repeat;
	} evt_t;

	typedef struct packed {
		code_t out_code;
		logic  out_press;
		logic  out_repeat;
		logic  last;
	} res_t;

	typedef struct packed {
		evt_t evt;
		logic is_pair;
	} job_t;

endpackage

/* design/ksmm_ram.sv */
module ksmm_ram #(
	parameter int unsigned Width = 1,
	parameter int unsigned Depth = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/ksmm_front.sv */
module ksmm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            evt_valid,
	output logic            evt_ready,
	input  ksmm_pkg::evt_t  evt,
	output logic            job_valid,
	input  logic            job_pop,
	output ksmm_pkg::job_t  job
);
	import ksmm_pkg::*;

	job_t        buf_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	job_t        job_new;

	// classify: left/right modifier pair codes
	always_comb begin
		job_new.evt     = evt;
		job_new.is_pair = evt.key_code inside {[CodeLShift:CodeRAlt]};
	end

	assign evt_ready = (cnt_q != 2'd2);
	assign push      = evt_valid && evt_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_pop && job_valid;
	assign job       = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= job_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* design/ksmm_back.sv */
module ksmm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_pop,
	input  ksmm_pkg::job_t  job,
	output logic            res_valid,
	input  logic            res_ready,
	output ksmm_pkg::res_t  res
);
	import ksmm_pkg::*;

	typedef enum logic [2:0] {
		StIdle = 3'b001,
		StExec = 3'b010,
		StGen  = 3'b100
	} bk_state_t;

	bk_state_t            state_q;
	bk_state_t            state_d;
	job_t                 cur_q;
	code_t                gen_q;
	logic                 gen_val_q;
	logic [NumKeys-1:0]   vld_q;
	logic [ModKeys-1:0]   mod_q;
	logic [ModKeys-1:0]   mod_n;
	logic                 vld_s2;
	logic                 byp_hit_s2;
	logic                 byp_val_s2;
	res_t                 res_q;
	logic                 res_valid_q;

	logic                 out_free;
	logic                 rd_data;
	logic                 held;
	logic                 emit;
	res_t                 emit_res;
	logic                 wr_en;
	code_t                wr_addr;
	logic                 wr_data;
	logic                 done;
	logic                 go_gen;
	logic                 issue;
	logic                 prior;
	logic                 after;
	logic [1:0]           pidx;
	logic [ModW-1:0]      mod_lo;
	logic [ModW-1:0]      mod_hi;
	code_t                gen_code;

	ksmm_ram #(
		.Width(1),
		.Depth(NumKeys)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (job.evt.key_code),
		.rd_data (rd_data)
	);

	assign out_free = !res_valid_q || res_ready;
	assign held     = byp_hit_s2 ? byp_val_s2 : (vld_s2 & rd_data);
	assign pidx     = cur_q.evt.key_code[2:1];
	assign mod_lo   = {pidx, 1'b0};
	assign mod_hi   = {pidx, 1'b1};
	assign gen_code = CodeShift + code_t'(pidx);

	always_comb begin
		mod_n = mod_q;
		if (cur_q.is_pair) begin
			mod_n[cur_q.evt.key_code[ModW-1:0]] = cur_q.evt.is_press;
		end
		prior = mod_q[mod_lo] | mod_q[mod_hi];
		after = mod_n[mod_lo] | mod_n[mod_hi];
	end

	always_comb begin
		emit     = 1'b0;
		emit_res = '0;
		wr_en    = 1'b0;
		wr_addr  = cur_q.evt.key_code;
		wr_data  = cur_q.evt.is_press;
		done     = 1'b0;
		go_gen   = 1'b0;
		case (state_q)
			StExec: begin
				emit_res.out_code   = cur_q.evt.key_code;
				emit_res.out_press  = cur_q.evt.is_press;
				emit_res.out_repeat = cur_q.evt.is_press & cur_q.evt.is_repeat;
				emit_res.last       = 1'b1;
				if (cur_q.evt.is_press && held) begin
					// held key pressed again: forwarded, map untouched
					emit = out_free;
					done = out_free;
				end else if (!cur_q.evt.is_press && !held) begin
					done = 1'b1;
				end else if (out_free) begin
					wr_en = 1'b1;
					emit  = 1'b1;
					if (cur_q.is_pair && (prior != after)) begin
						emit_res.last = 1'b0;
						go_gen        = 1'b1;
					end else begin
						done = 1'b1;
					end
				end
			end
			StGen: begin
				emit_res.out_code   = gen_q;
				emit_res.out_press  = gen_val_q;
				emit_res.out_repeat = 1'b0;
				emit_res.last       = 1'b1;
				wr_addr             = gen_q;
				wr_data             = gen_val_q;
				if (out_free) begin
					wr_en = 1'b1;
					emit  = 1'b1;
					done  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign issue   = job_valid && ((state_q == StIdle) || done);
	assign job_pop = issue;

	always_comb begin
		if (go_gen) begin
			state_d = StGen;
		end else if (issue) begin
			state_d = StExec;
		end else if (done) begin
			state_d = StIdle;
		end else begin
			state_d = state_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cur_q      <= job;
			byp_val_s2 <= wr_data;
		end
		if (go_gen) begin
			gen_q     <= gen_code;
			gen_val_q <= after;
		end
		if (emit) begin
			res_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			vld_q       <= '0;
			mod_q       <= '0;
			vld_s2      <= 1'b0;
			byp_hit_s2  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (wr_en && (state_q == StExec) && cur_q.is_pair) begin
				mod_q <= mod_n;
			end
			if (issue) begin
				// catch a write landing on the address being read this cycle
				vld_s2     <= vld_q[job.evt.key_code];
				byp_hit_s2 <= wr_en && (wr_addr == job.evt.key_code);
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* design/key_state_modifier_merger.sv */
// path: an accepted event goes into the front queue, then the back end's job register,
// and its result into the output register; one event per cycle unless res_ready stalls
// for one result; a generic result also needs StGen, as the key map has one write port
// reset: arst_n clears the key valid bits so every key reads as up, and empties the queue
// and the output register
module key_state_modifier_merger (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            evt_valid,
	output logic            evt_ready,
	input  ksmm_pkg::evt_t  evt,
	output logic            res_valid,
	input  logic            res_ready,
	output ksmm_pkg::res_t  res
);
	import ksmm_pkg::*;

	logic job_valid;
	logic job_pop;
	job_t job;

	ksmm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job)
	);

	ksmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
